[rtl/core/mfb_pkg.sv]
// mfb_pkg: shared constants, codes and structs of the mono frame buffer blitter
// no dependencies; compiled first

package mfb_pkg;

   // sizes of the frame store and of coordinates
   localparam int FB_BYTES        = 8192;
   localparam int FB_ADDR_BITS    = $clog2(FB_BYTES);
   localparam int COORD_BITS      = 10;
   localparam int PIXELS_PER_ITEM = 8;
   localparam int PIX_CNT_BITS    = (PIXELS_PER_ITEM > 1) ? $clog2(PIXELS_PER_ITEM) : 1;
   localparam int BIT_ADDR_BITS   = 16;
   localparam int PROD_BITS       = 2 * COORD_BITS;

   // field widths of the channels
   localparam int FUNC_BITS      = 2;
   localparam int SRC_BITS       = 8;
   localparam int READ_ADDR_BITS = 13;
   localparam int STATUS_BITS    = 2;
   localparam int DATA_BITS      = 8;
   localparam int CSR_INDEX_BITS = 3;

   // bit position within a byte
   localparam logic [2:0] BIT_IN_BYTE = 3'h7;
   localparam logic [2:0] MSB_POS     = 3'd7;

   // operation codes
   localparam logic [FUNC_BITS-1:0] FUNC_BEGIN = 2'd0;
   localparam logic [FUNC_BITS-1:0] FUNC_SRC   = 2'd1;
   localparam logic [FUNC_BITS-1:0] FUNC_FILL  = 2'd2;
   localparam logic [FUNC_BITS-1:0] FUNC_READ  = 2'd3;

   // status codes
   localparam logic [STATUS_BITS-1:0] STATUS_DONE    = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_REJECT  = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_IGNORED = 2'd2;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] REG_X_START   = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_Y_START   = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_X_END     = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_Y_END     = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_ROW_PITCH = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] REG_ROW_LIMIT = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] REG_INVERT    = 3'd6;

   // drawing registers as seen by the engine
   typedef struct packed {
      logic [COORD_BITS-1:0] x_start;
      logic [COORD_BITS-1:0] y_start;
      logic [COORD_BITS-1:0] x_end;
      logic [COORD_BITS-1:0] y_end;
      logic [COORD_BITS-1:0] row_pitch;
      logic [COORD_BITS-1:0] row_limit;
      logic                  invert;
   } cfg_type;

   // frame store access from the engine
   typedef struct packed {
      logic                    wr_en;
      logic [FB_ADDR_BITS-1:0] wr_addr;
      logic [DATA_BITS-1:0]    wr_data;
      logic [FB_ADDR_BITS-1:0] rd_addr;
   } mem_req_type;

   // engine status for checks at the top level
   typedef struct packed {
      logic clearing;
      logic stage_busy;
   } eng_status_type;

endpackage

[rtl/core/mfb_if.sv]
// mfb_if: valid/ready channel interfaces for requests, responses and register writes
// depends on mfb_pkg for field widths

interface mfb_req_if import mfb_pkg::*; ;
   logic                      valid;
   logic                      ready;
   logic [FUNC_BITS-1:0]      func;
   logic [SRC_BITS-1:0]       src_bits;
   logic [READ_ADDR_BITS-1:0] read_addr;

   modport source (output valid, func, src_bits, read_addr, input ready);
   modport sink   (input valid, func, src_bits, read_addr, output ready);
endinterface

interface mfb_rsp_if import mfb_pkg::*; ;
   logic                   valid;
   logic                   ready;
   logic [STATUS_BITS-1:0] status;
   logic [DATA_BITS-1:0]   read_data;
   logic                   blit_done;

   modport source (output valid, status, read_data, blit_done, input ready);
   modport sink   (input valid, status, read_data, blit_done, output ready);
endinterface

interface mfb_csr_if import mfb_pkg::*; ;
   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] index;
   logic [COORD_BITS-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[rtl/core/mfb_ram.sv]
// mfb_ram: generic single-clock ram, one write and one registered read port
// read returns the old contents when both ports hit the same entry

module mfb_ram #(
   parameter int DEPTH = 8192,
   parameter int WIDTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // storage array
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/mfb_csr.sv]
// mfb_csr: drawing register file written through the register channel
// depends on mfb_pkg and mfb_csr_if

module mfb_csr import mfb_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   mfb_csr_if.sink   csr_chan,
   output cfg_type   cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_chan.ready = 1'b1;

   // register decode; unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         unique case (csr_chan.index)
            REG_X_START:   cfg_in.x_start   = csr_chan.data;
            REG_Y_START:   cfg_in.y_start   = csr_chan.data;
            REG_X_END:     cfg_in.x_end     = csr_chan.data;
            REG_Y_END:     cfg_in.y_end     = csr_chan.data;
            REG_ROW_PITCH: cfg_in.row_pitch = csr_chan.data;
            REG_ROW_LIMIT: cfg_in.row_limit = csr_chan.data;
            REG_INVERT:    cfg_in.invert    = csr_chan.data[0];
            default:       cfg_in           = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[rtl/core/mfb_engine.sv]
// mfb_engine: command sequencer, pixel read-modify-write pipe and response register
// depends on mfb_pkg, mfb_req_if and mfb_rsp_if; drives the frame store ram

module mfb_engine import mfb_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  cfg_type         cfg,
   mfb_req_if.sink         req_chan,
   mfb_rsp_if.source       rsp_chan,
   output mem_req_type     mem_req,
   input  logic [DATA_BITS-1:0] mem_rdata,
   output eng_status_type  eng_sts
);

   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_SETUP  = 3'd2;
   localparam logic [2:0] ST_PIX    = 3'd3;
   localparam logic [2:0] ST_READ   = 3'd4;
   localparam logic [2:0] ST_FINISH = 3'd5;

   logic [2:0]               state_ff, state_in;
   logic                     op_fill_ff, op_fill_in;
   logic [FB_ADDR_BITS-1:0]  clr_addr_ff, clr_addr_in;
   logic [COORD_BITS-1:0]    cursor_col_ff, cursor_col_in;
   logic [COORD_BITS-1:0]    cursor_row_ff, cursor_row_in;
   logic                     blit_active_ff, blit_active_in;
   logic [COORD_BITS-1:0]    fill_col_ff, fill_col_in;
   logic [COORD_BITS-1:0]    fill_row_ff, fill_row_in;
   logic [BIT_ADDR_BITS-1:0] row_base_ff, row_base_in;
   logic [SRC_BITS-1:0]      src_ff, src_in;
   logic [PIX_CNT_BITS-1:0]  pix_cnt_ff, pix_cnt_in;
   logic [STATUS_BITS-1:0]   res_status_ff, res_status_in;
   logic [DATA_BITS-1:0]     res_data_ff, res_data_in;
   logic                     res_done_ff, res_done_in;
   logic                     stg_valid_ff, stg_valid_in;
   logic [FB_ADDR_BITS-1:0]  stg_idx_ff, stg_idx_in;
   logic [DATA_BITS-1:0]     stg_mask_ff, stg_mask_in;
   logic                     stg_set_ff, stg_set_in;
   logic                     wr_valid_ff;
   logic [FB_ADDR_BITS-1:0]  wr_idx_ff;
   logic [DATA_BITS-1:0]     wr_data_ff;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [STATUS_BITS-1:0]   rsp_status_ff, rsp_status_in;
   logic [DATA_BITS-1:0]     rsp_data_ff, rsp_data_in;
   logic                     rsp_done_ff, rsp_done_in;

   logic                     req_accept;
   logic                     rect_ok;
   logic [COORD_BITS-1:0]    work_col;
   logic [COORD_BITS-1:0]    work_row;
   logic [PROD_BITS-1:0]     row_prod;
   logic [BIT_ADDR_BITS-1:0] pix_addr;
   logic [2:0]               pix_pos;
   logic [COORD_BITS-1:0]    col_next;
   logic [COORD_BITS-1:0]    row_next;
   logic [COORD_BITS:0]      fill_row_next;
   logic [DATA_BITS-1:0]     merge_base;
   logic [DATA_BITS-1:0]     merge_data;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_accept     = req_chan.valid && req_chan.ready;

   // rectangle check against the display limits
   assign rect_ok = (cfg.x_start <= cfg.row_pitch) && (cfg.y_start <= cfg.row_limit)
                 && (cfg.x_end <= cfg.row_pitch) && (cfg.y_end <= cfg.row_limit)
                 && (cfg.x_start <= cfg.x_end) && (cfg.y_start <= cfg.y_end);

   // pixel address of the current pixel
   assign work_col = op_fill_ff ? fill_col_ff : cursor_col_ff;
   assign work_row = op_fill_ff ? fill_row_ff : cursor_row_ff;
   assign row_prod = PROD_BITS'(work_row) * PROD_BITS'(cfg.row_pitch);
   assign pix_addr = row_base_ff + BIT_ADDR_BITS'(work_col);
   assign pix_pos  = op_fill_ff ? (MSB_POS - (pix_addr[2:0] & BIT_IN_BYTE))
                                : (pix_addr[2:0] & BIT_IN_BYTE);

   assign col_next      = cursor_col_ff + COORD_BITS'(1);
   assign row_next      = cursor_row_ff + COORD_BITS'(1);
   assign fill_row_next = {1'b0, fill_row_ff} + (COORD_BITS+1)'(1);

   // modify stage, forwarding the byte written in the previous cycle
   assign merge_base = (wr_valid_ff && (wr_idx_ff == stg_idx_ff)) ? wr_data_ff : mem_rdata;
   assign merge_data = stg_set_ff ? (merge_base | stg_mask_ff) : (merge_base & ~stg_mask_ff);

   // frame store port selection
   always_comb begin
      mem_req.wr_en   = stg_valid_ff;
      mem_req.wr_addr = stg_idx_ff;
      mem_req.wr_data = merge_data;
      if (state_ff == ST_CLEAR) begin
         mem_req.wr_en   = 1'b1;
         mem_req.wr_addr = clr_addr_ff;
         mem_req.wr_data = '0;
      end
      if (state_ff == ST_IDLE) begin
         mem_req.rd_addr = req_chan.read_addr[FB_ADDR_BITS-1:0];
      end else begin
         mem_req.rd_addr = pix_addr[3 +: FB_ADDR_BITS];
      end
   end

   // sequencer
   always_comb begin
      state_in       = state_ff;
      op_fill_in     = op_fill_ff;
      clr_addr_in    = clr_addr_ff;
      cursor_col_in  = cursor_col_ff;
      cursor_row_in  = cursor_row_ff;
      blit_active_in = blit_active_ff;
      fill_col_in    = fill_col_ff;
      fill_row_in    = fill_row_ff;
      row_base_in    = row_base_ff;
      src_in         = src_ff;
      pix_cnt_in     = pix_cnt_ff;
      res_status_in  = res_status_ff;
      res_data_in    = res_data_ff;
      res_done_in    = res_done_ff;
      stg_valid_in   = 1'b0;
      stg_idx_in     = stg_idx_ff;
      stg_mask_in    = stg_mask_ff;
      stg_set_in     = stg_set_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_data_in    = rsp_data_ff;
      rsp_done_in    = rsp_done_ff;

      // response taken downstream
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            clr_addr_in = clr_addr_ff + FB_ADDR_BITS'(1);
            if (clr_addr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            if (req_accept) begin
               res_status_in = STATUS_DONE;
               res_data_in   = '0;
               res_done_in   = 1'b0;
               unique case (req_chan.func)
                  FUNC_BEGIN: begin
                     state_in = ST_FINISH;
                     if (!rect_ok) begin
                        res_status_in  = STATUS_REJECT;
                        blit_active_in = 1'b0;
                     end else begin
                        cursor_col_in = cfg.x_start;
                        cursor_row_in = cfg.y_start;
                        if ((cfg.x_start == cfg.x_end) || (cfg.y_start == cfg.y_end)) begin
                           blit_active_in = 1'b0;
                           res_done_in    = 1'b1;
                        end else begin
                           blit_active_in = 1'b1;
                        end
                     end
                  end
                  FUNC_SRC: begin
                     if (!blit_active_ff) begin
                        res_status_in = STATUS_IGNORED;
                        state_in      = ST_FINISH;
                     end else begin
                        src_in     = req_chan.src_bits;
                        pix_cnt_in = '0;
                        op_fill_in = 1'b0;
                        state_in   = ST_SETUP;
                     end
                  end
                  FUNC_FILL: begin
                     if (!rect_ok) begin
                        res_status_in = STATUS_REJECT;
                        state_in      = ST_FINISH;
                     end else if (cfg.y_start == cfg.y_end) begin
                        state_in = ST_FINISH;
                     end else begin
                        fill_col_in = cfg.x_start;
                        fill_row_in = cfg.y_start;
                        op_fill_in  = 1'b1;
                        state_in    = ST_SETUP;
                     end
                  end
                  FUNC_READ: begin
                     state_in = ST_READ;
                  end
                  default: begin
                     state_in = ST_FINISH;
                  end
               endcase
            end
         end

         ST_SETUP: begin
            row_base_in = row_prod[BIT_ADDR_BITS-1:0];
            state_in    = ST_PIX;
         end

         ST_PIX: begin
            // issue one pixel into the modify stage
            stg_valid_in = 1'b1;
            stg_idx_in   = pix_addr[3 +: FB_ADDR_BITS];
            stg_mask_in  = DATA_BITS'(1) << pix_pos;
            if (op_fill_ff) begin
               stg_set_in = !cfg.invert;
               if (fill_col_ff == cfg.x_end) begin
                  fill_col_in = cfg.x_start;
                  fill_row_in = fill_row_next[COORD_BITS-1:0];
                  row_base_in = row_base_ff + BIT_ADDR_BITS'(cfg.row_pitch);
                  if (fill_row_next >= {1'b0, cfg.y_end}) begin
                     state_in = ST_FINISH;
                  end
               end else begin
                  fill_col_in = fill_col_ff + COORD_BITS'(1);
               end
            end else begin
               stg_set_in = src_ff[0] ^ cfg.invert;
               src_in     = src_ff >> 1;
               pix_cnt_in = pix_cnt_ff + PIX_CNT_BITS'(1);
               if (pix_cnt_ff == PIX_CNT_BITS'(PIXELS_PER_ITEM - 1)) begin
                  state_in = ST_FINISH;
               end
               if (col_next >= cfg.x_end) begin
                  cursor_col_in = cfg.x_start;
                  cursor_row_in = row_next;
                  // row counter wraps to the top of the store
                  if (row_next == '0) begin
                     row_base_in = '0;
                  end else begin
                     row_base_in = row_base_ff + BIT_ADDR_BITS'(cfg.row_pitch);
                  end
                  if (row_next >= cfg.y_end) begin
                     blit_active_in = 1'b0;
                     res_done_in    = 1'b1;
                     state_in       = ST_FINISH;
                  end
               end else begin
                  cursor_col_in = col_next;
               end
            end
         end

         ST_READ: begin
            res_data_in = mem_rdata;
            state_in    = ST_FINISH;
         end

         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_data_in   = res_data_ff;
               rsp_done_in   = res_done_ff;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         clr_addr_ff    <= '0;
         cursor_col_ff  <= '0;
         cursor_row_ff  <= '0;
         blit_active_ff <= 1'b0;
         stg_valid_ff   <= 1'b0;
         wr_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         clr_addr_ff    <= clr_addr_in;
         cursor_col_ff  <= cursor_col_in;
         cursor_row_ff  <= cursor_row_in;
         blit_active_ff <= blit_active_in;
         stg_valid_ff   <= stg_valid_in;
         wr_valid_ff    <= stg_valid_ff;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_fill_ff    <= op_fill_in;
      fill_col_ff   <= fill_col_in;
      fill_row_ff   <= fill_row_in;
      row_base_ff   <= row_base_in;
      src_ff        <= src_in;
      pix_cnt_ff    <= pix_cnt_in;
      res_status_ff <= res_status_in;
      res_data_ff   <= res_data_in;
      res_done_ff   <= res_done_in;
      stg_idx_ff    <= stg_idx_in;
      stg_mask_ff   <= stg_mask_in;
      stg_set_ff    <= stg_set_in;
      wr_idx_ff     <= stg_idx_ff;
      wr_data_ff    <= merge_data;
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_done_ff   <= rsp_done_in;
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.status    = rsp_status_ff;
   assign rsp_chan.read_data = rsp_data_ff;
   assign rsp_chan.blit_done = rsp_done_ff;

   assign eng_sts.clearing   = (state_ff == ST_CLEAR);
   assign eng_sts.stage_busy = stg_valid_ff;

endmodule

[rtl/core/mono_framebuffer_blit_fill.sv]
// mono_framebuffer_blit_fill: top level of the 1-bit-per-pixel blitter and rectangle filler
// depends on mfb_pkg, mfb_if, mfb_ram, mfb_csr and mfb_engine
//
//   channel    direction  carries
//   req_chan   in         func, src_bits, read_addr
//   rsp_chan   out        status, read_data, blit_done
//   csr_chan   in         index, data (drawing registers)
//
// begin blit, ignored source byte, rejected rectangle: the finish step registers the response
// readback: read step, then finish step; source byte: a setup step, one pixel per cycle (up to 8), drain
// fill: a setup step, one pixel per cycle from x_start to x_end in each row, drain; one frame store
// read-modify-write per cycle is the limit, a same-byte write is forwarded
// after reset a clearing pass zeroes all 8192 bytes of the frame store; no transaction is
// taken meanwhile, register writes are. the response register lets the next transaction
// be taken while a result waits; the engine holds in its finish step while both wait

module mono_framebuffer_blit_fill import mfb_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   mfb_req_if.sink    req_chan,
   mfb_rsp_if.source  rsp_chan,
   mfb_csr_if.sink    csr_chan
);

   cfg_type              cfg;
   mem_req_type          mem_req;
   logic [DATA_BITS-1:0] mem_rdata;
   eng_status_type       eng_sts;

   // drawing registers
   mfb_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   // frame store
   mfb_ram #(
      .DEPTH (FB_BYTES),
      .WIDTH (DATA_BITS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_req.wr_en),
      .wr_addr (mem_req.wr_addr),
      .wr_data (mem_req.wr_data),
      .rd_addr (mem_req.rd_addr),
      .rd_data (mem_rdata)
   );

   // command engine
   mfb_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .mem_req   (mem_req),
      .mem_rdata (mem_rdata),
      .eng_sts   (eng_sts)
   );

   // no transaction taken during the clearing pass
   a_no_req_while_clearing : assert property (@(posedge clock) disable iff (reset)
      eng_sts.clearing |-> !req_chan.ready)
      else $error("request taken during frame store clearing");

   // a pixel write in flight keeps new transactions out
   a_no_req_while_writing : assert property (@(posedge clock) disable iff (reset)
      eng_sts.stage_busy |-> !req_chan.ready)
      else $error("request taken with a pixel write pending");

   // reset always starts the clearing pass
   a_clear_after_reset : assert property (@(posedge clock)
      reset |=> eng_sts.clearing)
      else $error("clearing pass not started after reset");

endmodule
